// ===== rtl/core/cpsu_pkg.sv =====
// shared types, constants and a saturation helper for the clamped pid step unit
package cpsu_pkg;

  localparam int DATA_W   = 32;
  localparam int BOUND_W  = 31;
  localparam int DT_W     = 17;
  localparam int WIDE_W   = 50;
  localparam int FRAC_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int STAGES   = 6;

  localparam logic [DT_W-1:0]    STEP_TIME_RST = DT_W'(2185);
  localparam logic [BOUND_W-1:0] BOUND_RST     = {BOUND_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_STEP_TIME   = 3'd3,
    REG_ERR_BOUND   = 3'd4,
    REG_VEL_BOUND   = 3'd5,
    REG_INTEG_BOUND = 3'd6,
    REG_DRIVE_BOUND = 3'd7
  } cpsu_reg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] gain_p;
    logic signed [DATA_W-1:0] gain_i;
    logic signed [DATA_W-1:0] gain_d;
    logic [DT_W-1:0]          step_time;
    logic [BOUND_W-1:0]       err_bound;
    logic [BOUND_W-1:0]       vel_bound;
    logic [BOUND_W-1:0]       integ_bound;
    logic [BOUND_W-1:0]       drive_bound;
  } cpsu_cfg_t;

  // symmetric saturation of a wide signed value
  function automatic logic signed [DATA_W-1:0] clamp_sym(
    input logic signed [WIDE_W-1:0] v,
    input logic [BOUND_W-1:0]       b
  );
    logic signed [WIDE_W-1:0] pos;
    logic signed [WIDE_W-1:0] neg;
    logic signed [DATA_W-1:0] res;
    pos = signed'({{(WIDE_W-BOUND_W){1'b0}}, b});
    neg = -pos;
    if (v > pos) begin
      res = pos[DATA_W-1:0];
    end else if (v < neg) begin
      res = neg[DATA_W-1:0];
    end else begin
      res = v[DATA_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/cpsu_in_if.sv =====
// request channel carrying one sample of command and measurement
interface cpsu_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [cpsu_pkg::DATA_W-1:0] cmd_position;
  logic signed [cpsu_pkg::DATA_W-1:0] cmd_velocity;
  logic signed [cpsu_pkg::DATA_W-1:0] meas_position;
  logic signed [cpsu_pkg::DATA_W-1:0] meas_velocity;

  modport source (
    output valid, cmd_position, cmd_velocity, meas_position, meas_velocity,
    input  ready
  );
  modport sink (
    input  valid, cmd_position, cmd_velocity, meas_position, meas_velocity,
    output ready
  );
endinterface

// ===== rtl/core/cpsu_out_if.sv =====
// result channel carrying the clamped drive
interface cpsu_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [cpsu_pkg::DATA_W-1:0] drive;

  modport source (
    output valid, drive,
    input  ready
  );
  modport sink (
    input  valid, drive,
    output ready
  );
endinterface

// ===== rtl/core/clamped_pid_step_unit.sv =====
// clamped pid step unit top level
// Takes one sample per cycle while the result side does not stall and returns one
// drive value per sample. The pipeline runs input register, error clamp, gain
// multiply, integrator update, integral multiply and output clamp; the integrator
// loop closes around the single add-and-saturate in stage three, so a new sample
// enters every cycle that the result side does not stall. A stalled result holds
// the output register while earlier stages keep filling bubbles.
// Write configuration only with no request in flight.
module clamped_pid_step_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cpsu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cpsu_pkg::DATA_W-1:0]    cfg_wdata,
  cpsu_in_if.sink                        in_ch,
  cpsu_out_if.source                     out_ch
);
  import cpsu_pkg::*;

  cpsu_cfg_t cfg;

  cpsu_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cpsu_pipe u_pipe (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

// ===== rtl/core/cpsu_cfg_regs.sv =====
// gain, step time and bound registers behind the write port
module cpsu_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cpsu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cpsu_pkg::DATA_W-1:0]       cfg_wdata,
  output cpsu_pkg::cpsu_cfg_t               cfg
);
  import cpsu_pkg::*;

  cpsu_cfg_t cfg_r;
  cpsu_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cpsu_reg_idx_t'(cfg_index))
        REG_GAIN_P:      cfg_nxt.gain_p      = signed'(cfg_wdata);
        REG_GAIN_I:      cfg_nxt.gain_i      = signed'(cfg_wdata);
        REG_GAIN_D:      cfg_nxt.gain_d      = signed'(cfg_wdata);
        REG_STEP_TIME:   cfg_nxt.step_time   = cfg_wdata[DT_W-1:0];
        REG_ERR_BOUND:   cfg_nxt.err_bound   = cfg_wdata[BOUND_W-1:0];
        REG_VEL_BOUND:   cfg_nxt.vel_bound   = cfg_wdata[BOUND_W-1:0];
        REG_INTEG_BOUND: cfg_nxt.integ_bound = cfg_wdata[BOUND_W-1:0];
        REG_DRIVE_BOUND: cfg_nxt.drive_bound = cfg_wdata[BOUND_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p      <= '0;
      cfg_r.gain_i      <= '0;
      cfg_r.gain_d      <= '0;
      cfg_r.step_time   <= STEP_TIME_RST;
      cfg_r.err_bound   <= BOUND_RST;
      cfg_r.vel_bound   <= BOUND_RST;
      cfg_r.integ_bound <= BOUND_RST;
      cfg_r.drive_bound <= BOUND_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/cpsu_pipe.sv =====
// six stage pid datapath with integrator feedback and stall handling
module cpsu_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  cpsu_pkg::cpsu_cfg_t cfg,
  cpsu_in_if.sink             in_ch,
  cpsu_out_if.source          out_ch
);
  import cpsu_pkg::*;

  logic [STAGES-1:0] v_r;
  logic [STAGES-1:0] v_nxt;
  logic [STAGES-1:0] rdy;

  // stage 0: input register
  logic signed [DATA_W-1:0] s0_cp_r, s0_cv_r, s0_mp_r, s0_mv_r;
  // stage 1: clamped errors
  logic signed [DATA_W:0]   pos_diff, vel_diff;
  logic signed [DATA_W-1:0] s1_err_r, s1_vel_r;
  // stage 2: products
  logic signed [2*DATA_W-1:0] s2_kp_r, s2_kd_r;
  logic signed [WIDE_W-1:0]   s2_dt_r;
  // stage 3: integrator step, partial sum
  logic signed [DATA_W-1:0]   integ_r;
  logic signed [DATA_W+2:0]   integ_sum;
  logic signed [DATA_W-1:0]   integ_nxt;
  logic signed [2*DATA_W-FRAC_W:0] s3_pd_r;
  logic signed [DATA_W-1:0]   s3_integ_old_r;
  // stage 4: integral product
  logic signed [2*DATA_W-1:0] s4_ki_r;
  logic signed [2*DATA_W-FRAC_W:0] s4_pd_r;
  // stage 5: output register
  logic signed [WIDE_W-1:0]   drive_sum;
  logic signed [DATA_W-1:0]   drive_r;

  always_comb begin
    rdy[STAGES-1] = !v_r[STAGES-1] || out_ch.ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
    v_nxt[0] = rdy[0] ? in_ch.valid : v_r[0];
    for (int i = 1; i < STAGES; i++) begin
      v_nxt[i] = rdy[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ch.ready  = rdy[0];
  assign out_ch.valid = v_r[STAGES-1];
  assign out_ch.drive = drive_r;

  assign pos_diff = {s0_cp_r[DATA_W-1], s0_cp_r} - {s0_mp_r[DATA_W-1], s0_mp_r};
  assign vel_diff = {s0_cv_r[DATA_W-1], s0_cv_r} - {s0_mv_r[DATA_W-1], s0_mv_r};

  // integrator feedback: add and saturate
  assign integ_sum = {{3{integ_r[DATA_W-1]}}, integ_r}
                   + {s2_dt_r[WIDE_W-1], s2_dt_r[WIDE_W-1:FRAC_W]};
  assign integ_nxt = clamp_sym(
    signed'({{(WIDE_W-DATA_W-3){integ_sum[DATA_W+2]}}, integ_sum}), cfg.integ_bound);

  assign drive_sum = {s4_pd_r[2*DATA_W-FRAC_W], s4_pd_r}
                   + {{2{s4_ki_r[2*DATA_W-1]}}, s4_ki_r[2*DATA_W-1:FRAC_W]};

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_cp_r <= in_ch.cmd_position;
      s0_cv_r <= in_ch.cmd_velocity;
      s0_mp_r <= in_ch.meas_position;
      s0_mv_r <= in_ch.meas_velocity;
    end
    if (rdy[1]) begin
      s1_err_r <= clamp_sym(
        signed'({{(WIDE_W-DATA_W-1){pos_diff[DATA_W]}}, pos_diff}), cfg.err_bound);
      s1_vel_r <= clamp_sym(
        signed'({{(WIDE_W-DATA_W-1){vel_diff[DATA_W]}}, vel_diff}), cfg.vel_bound);
    end
    if (rdy[2]) begin
      s2_kp_r <= s1_err_r * cfg.gain_p;
      s2_kd_r <= s1_vel_r * cfg.gain_d;
      s2_dt_r <= s1_err_r * signed'({1'b0, cfg.step_time});
    end
    if (rdy[3]) begin
      s3_pd_r <= {s2_kp_r[2*DATA_W-1], s2_kp_r[2*DATA_W-1:FRAC_W]}
               + {s2_kd_r[2*DATA_W-1], s2_kd_r[2*DATA_W-1:FRAC_W]};
      s3_integ_old_r <= integ_r;
    end
    if (rdy[4]) begin
      s4_ki_r <= s3_integ_old_r * cfg.gain_i;
      s4_pd_r <= s3_pd_r;
    end
    if (rdy[5]) begin
      drive_r <= clamp_sym(drive_sum, cfg.drive_bound);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (rdy[3] && v_r[2]) begin
      integ_r <= integ_nxt;
    end
  end

`ifndef SYNTH
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v_r == {STAGES{1'b1}}))
    else $error("input blocked with a bubble in the pipeline");

  a_integ_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(rdy[3] && v_r[2]) |=> $stable(integ_r))
    else $error("integrator moved without a request leaving stage two");

  a_out_from_stage4: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v_r[STAGES-1]) |-> $past(v_r[STAGES-2]))
    else $error("result appeared without a request in stage four");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v_r[0])
    else $error("accepted request lost at the input register");
`endif

endmodule
